// ===== src/bsat_pkg.sv =====
package bsat_pkg;

  localparam int NumTypesDef     = 8;
  localparam int PendingDepthDef = 64;
  localparam int AckedDepthDef   = 64;

  localparam int OpW     = 2;
  localparam int TypeW   = 3;
  localparam int SeqW    = 64;
  localparam int StatusW = 2;
  localparam int RetW    = 7;
  localparam int CfgW    = 4;

  typedef enum logic [OpW-1:0] {
    OP_REQUEST = 2'd0,
    OP_REPLY   = 2'd1,
    OP_COLLECT = 2'd2,
    OP_FLUSH   = 2'd3
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_TYPE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD_RD,
    S_RETIRE,
    S_COL_RD,
    S_COL_OUT,
    S_OUT
  } state_t;

endpackage

// ===== src/bsat_ram.sv =====
// Simple one-write, one-read memory with registered read data.
module bsat_ram #(
  parameter int Depth = 64,
  parameter int Width = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/barrier_seqno_ack_tracker.sv =====
// Barrier sequence-number acknowledgement tracker. The block handles one request
// at a time and drops in_stall only when it is idle. A new request, a flush or a
// bad-type request passes from acceptance through a table lookup to the result.
// A barrier reply goes through one lookup and retire step per retired entry,
// because each retirement reads the head of the pending queue memory and then
// writes the acked list memory. A collect goes through one acked memory read per
// result, and an empty collect goes straight from the lookup to the result.
// An output stall holds the result. There is no clearing pass after reset.
module barrier_seqno_ack_tracker
  import bsat_pkg::*;
#(
  parameter int NUM_TYPES     = NumTypesDef,
  parameter int PENDING_DEPTH = PendingDepthDef,
  parameter int ACKED_DEPTH   = AckedDepthDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgW-1:0]       cfg_active_types,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OpW-1:0]        in_opcode,
  input  logic [TypeW-1:0]      in_seq_type,
  input  logic [SeqW-1:0]       in_app_seqno,
  input  logic [SeqW-1:0]       in_barrier_seqno,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [StatusW-1:0]    out_status,
  output logic [SeqW-1:0]       out_request_seqno,
  output logic [RetW-1:0]       out_retired_count,
  output logic [SeqW-1:0]       out_acked_value,
  output logic                  out_acked_valid,
  output logic [SeqW-1:0]       out_current_seqno,
  output logic                  out_acked_overflow,
  output logic                  out_last
);
  localparam int PW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int AW  = (ACKED_DEPTH > 1) ? $clog2(ACKED_DEPTH) : 1;
  localparam int ACW = $clog2(ACKED_DEPTH + 1);
  localparam int TW  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int AMW = TW + AW;
  localparam int AMD = NUM_TYPES * (1 << AW);
  localparam int PEW = TypeW + 2 * SeqW;

  state_t state_r, state_nxt;

  logic [CfgW-1:0]      active_r;
  logic [SeqW-1:0]      counter_r;
  logic [PW-1:0]        head_r;
  logic [PCW-1:0]       pfill_r;
  logic [SeqW-1:0]      cur_r [NUM_TYPES];
  logic [SeqW-1:0]      req_r [NUM_TYPES];
  logic [ACW-1:0]       afill_r [NUM_TYPES];
  logic [NUM_TYPES-1:0] ovf_r;

  // Latched request.
  op_t              op_r;
  logic [TypeW-1:0] type_r;
  logic [SeqW-1:0]  app_r;
  logic [SeqW-1:0]  bar_r;
  logic             ok_r;
  logic [RetW-1:0]  ret_r;
  logic [ACW-1:0]   idx_r;
  logic [ACW-1:0]   ncol_r;
  logic             colovf_r;
  logic             in_app_eq;

  // Output register.
  logic [StatusW-1:0] o_status_r;
  logic               o_avalid_r;
  logic [SeqW-1:0]    o_lastack_r;
  logic               o_ovf_r;
  logic               o_last_r;

  // Memories.
  logic             pq_we;
  logic [PW-1:0]    pq_waddr;
  logic [PEW-1:0]   pq_wdata, pq_rdata;
  logic             am_we;
  logic [AMW-1:0]   am_waddr, am_raddr;
  logic [SeqW-1:0]  am_wdata, am_rdata;

  logic [TypeW-1:0] pt;
  logic [SeqW-1:0]  pbar, pval;
  assign pt   = pq_rdata[PEW-1 -: TypeW];
  assign pbar = pq_rdata[2*SeqW-1 -: SeqW];
  assign pval = pq_rdata[SeqW-1:0];

  logic             accept;
  logic             in_ok;
  logic [TW-1:0]    ti, pti;
  assign accept = in_valid && !in_stall;
  assign in_ok  = ({1'b0, in_seq_type} < active_r) &&
                  (32'(in_seq_type) < NUM_TYPES);
  assign ti     = TW'(type_r);
  assign pti    = TW'(pt);

  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);

  bsat_ram #(.Depth(1 << PW), .Width(PEW)) u_pq (
    .clk(clk), .we(pq_we), .waddr(pq_waddr), .wdata(pq_wdata),
    .raddr(head_r), .rdata(pq_rdata)
  );

  bsat_ram #(.Depth(AMD), .Width(SeqW)) u_am (
    .clk(clk), .we(am_we), .waddr(am_waddr), .wdata(am_wdata),
    .raddr(am_raddr), .rdata(am_rdata)
  );

  assign in_app_eq = (app_r == req_r[ti]);

  // Request push into the pending queue.
  logic req_push;
  logic [PCW:0] slot_sum;
  always_comb begin
    slot_sum = (PCW+1)'(head_r) + (PCW+1)'(pfill_r);
    if (slot_sum >= (PCW+1)'(PENDING_DEPTH)) begin
      slot_sum = slot_sum - (PCW+1)'(PENDING_DEPTH);
    end
    req_push = (state_r == S_HEAD_RD) && (op_r == OP_REQUEST) && ok_r &&
               (in_app_eq == 1'b0) && (32'(pfill_r) < PENDING_DEPTH);
  end

  assign pq_we    = req_push;
  assign pq_waddr = PW'(slot_sum);
  assign pq_wdata = {type_r, counter_r + 64'd1, app_r};

  // Retire step: head entry valid and covered by the reply.
  logic retire_go, acked_room;
  assign retire_go  = (state_r == S_RETIRE) && (pfill_r != '0) && (pbar <= bar_r);
  assign acked_room = (32'(afill_r[pti]) < ACKED_DEPTH);
  assign am_we      = retire_go && (32'(pt) < NUM_TYPES) && acked_room;
  assign am_waddr   = {pti, AW'(afill_r[pti])};
  assign am_wdata   = pval;
  assign am_raddr   = {ti, AW'(idx_r)};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (accept) state_nxt = S_HEAD_RD;
      S_HEAD_RD: begin
        case (op_r)
          OP_REPLY:   state_nxt = S_RETIRE;
          OP_COLLECT: state_nxt = (ok_r && afill_r[ti] != '0) ? S_COL_RD : S_OUT;
          default:    state_nxt = S_OUT;
        endcase
      end
      S_RETIRE:  state_nxt = retire_go ? S_HEAD_RD : S_OUT;
      S_COL_RD:  state_nxt = S_COL_OUT;
      S_COL_OUT: begin
        if (!out_stall) state_nxt = o_last_r ? S_IDLE : S_COL_RD;
      end
      S_OUT:     if (!out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      counter_r <= '0;
      head_r    <= '0;
      pfill_r   <= '0;
      ovf_r     <= '0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        cur_r[i]   <= '0;
        req_r[i]   <= '0;
        afill_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_active_types;
      end
      if (req_push) begin
        counter_r   <= counter_r + 64'd1;
        pfill_r     <= pfill_r + PCW'(1);
        req_r[ti]   <= app_r;
      end
      if (retire_go) begin
        head_r  <= (32'(head_r) == PENDING_DEPTH - 1) ? '0 : head_r + PW'(1);
        pfill_r <= pfill_r - PCW'(1);
        if (32'(pt) < NUM_TYPES) begin
          cur_r[pti] <= pval;
          if (acked_room) begin
            afill_r[pti] <= afill_r[pti] + ACW'(1);
          end else begin
            ovf_r[pti] <= 1'b1;
          end
        end
      end
      if (state_r == S_HEAD_RD && op_r == OP_COLLECT && ok_r) begin
        afill_r[ti] <= '0;
        ovf_r[ti]   <= 1'b0;
      end
      if (state_r == S_HEAD_RD && op_r == OP_FLUSH) begin
        counter_r <= '0;
        head_r    <= '0;
        pfill_r   <= '0;
        ovf_r     <= '0;
        for (int i = 0; i < NUM_TYPES; i++) afill_r[i] <= '0;
      end
    end
  end

  // Item latch and result formation.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_opcode);
      type_r <= in_seq_type;
      app_r  <= in_app_seqno;
      bar_r  <= in_barrier_seqno;
      ok_r   <= in_ok;
      ret_r  <= '0;
      idx_r  <= '0;
    end
    if (state_r == S_HEAD_RD) begin
      o_status_r  <= ST_DONE;
      o_avalid_r  <= 1'b0;
      o_last_r    <= 1'b1;
      o_lastack_r <= ok_r ? cur_r[ti] : '0;
      o_ovf_r     <= ok_r ? ovf_r[ti] : 1'b0;
      ncol_r      <= afill_r[ti];
      colovf_r    <= ovf_r[ti];
      case (op_r)
        OP_REQUEST: begin
          if (!ok_r) o_status_r <= ST_BAD_TYPE;
          else if (in_app_eq) o_status_r <= ST_IGNORED;
          else if (!(32'(pfill_r) < PENDING_DEPTH)) o_status_r <= ST_FULL;
        end
        OP_COLLECT: if (!ok_r) o_status_r <= ST_BAD_TYPE;
        OP_FLUSH:   o_ovf_r <= 1'b0;
        default:    ;
      endcase
    end
    if (state_r == S_RETIRE) begin
      o_lastack_r <= ok_r ? cur_r[ti] : '0;
      o_ovf_r     <= ok_r ? ovf_r[ti] : 1'b0;
      if (retire_go && ret_r != 7'd127) ret_r <= ret_r + 7'd1;
    end
    if (state_r == S_COL_RD) begin
      o_avalid_r <= 1'b1;
      o_ovf_r    <= colovf_r;
      o_last_r   <= (idx_r + ACW'(1) == ncol_r);
    end
    // The read address holds while a collected entry waits, so its data holds too.
    if (state_r == S_COL_OUT && !out_stall) begin
      idx_r <= idx_r + ACW'(1);
    end
  end

  assign out_valid          = (state_r == S_OUT) || (state_r == S_COL_OUT);
  assign out_status         = o_status_r;
  assign out_request_seqno  = counter_r;
  assign out_retired_count  = (op_r == OP_REPLY) ? ret_r : '0;
  assign out_acked_value    = (state_r == S_COL_OUT) ? am_rdata : '0;
  assign out_acked_valid    = o_avalid_r;
  assign out_current_seqno  = o_lastack_r;
  assign out_acked_overflow = o_ovf_r;
  assign out_last           = o_last_r;
endmodule

// ===== src/bsat_checker.sv =====
// Port-level checks for the tracker.
module bsat_checker
  import bsat_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_acked_valid,
  input logic               out_last,
  input logic [RetW-1:0]    out_retired_count,
  input logic [SeqW-1:0]    out_acked_value
);
  // Results never come while the block takes new requests.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result while ready");

  // An accepted request makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("ready right after request");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_last) &&
    $stable(out_acked_value))
    else $error("stalled result changed");

  // Collected entries carry no retire count.
  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_acked_valid |-> out_retired_count == '0)
    else $error("retire count on collect");

  // An empty slot shows a zero value.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_acked_valid |-> out_acked_value == '0)
    else $error("value without entry");
endmodule

bind barrier_seqno_ack_tracker bsat_checker u_bsat_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_acked_valid(out_acked_valid), .out_last(out_last),
  .out_retired_count(out_retired_count), .out_acked_value(out_acked_value)
);
